// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is high
`define AST_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// implication into the next cycle, off while reset is high
`define AST_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// implication into the next cycle, active during reset too
`define AST_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== sv/crtr_pkg.sv =====
// ----------------------------------------------------------------------------
// crtr_pkg
// types and constants of the two-prime crt limb recombiner
// ----------------------------------------------------------------------------
`default_nettype none

package crtr_pkg;

  localparam int LIMB_WIDTH = 64;
  localparam int ACC_WIDTH  = 2 * LIMB_WIDTH;
  localparam int RES_WIDTH  = 31;
  localparam int CFG_WIDTH  = 62;
  localparam int IDX_WIDTH  = 3;
  localparam int OFS_WIDTH  = 7;
  localparam int DIV_WIDTH  = 63;
  localparam int CNT_WIDTH  = 6;

  localparam logic [IDX_WIDTH-1:0] REG_PRIME_ONE = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_PRIME_TWO = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_INVERSE   = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_DIGIT     = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_PROD      = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_HALF      = 3'd5;

  typedef struct packed {
    logic [30:0] residue_p1;
    logic [30:0] residue_p2;
    logic        last_digit;
  } item_t;

  typedef struct packed {
    logic [63:0] pos_limb;
    logic [63:0] neg_limb;
    logic        last_limb;
  } result_t;

  typedef struct packed {
    logic [30:0] prime_one;
    logic [30:0] prime_two;
    logic [30:0] inverse_p1_mod_p2;
    logic [5:0]  digit_bits;
    logic [61:0] modulus_product;
    logic [60:0] half_modulus_product;
  } cfg_t;

  // classified digit handed from front to back
  typedef struct packed {
    logic [30:0] r1;
    logic [30:0] diff_mag;
    logic        diff_neg;
    logic        last;
  } digit_t;

  typedef struct packed {
    logic   avail;
    digit_t digit;
  } front_out_t;

endpackage

`default_nettype wire

// ===== sv/crtr_front.sv =====
// ----------------------------------------------------------------------------
// crtr_front
// accepts digit residue pairs, forms r2 - r1 and queues them for the back
// ----------------------------------------------------------------------------
`default_nettype none

module crtr_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire crtr_pkg::item_t     item,
  output crtr_pkg::front_out_t     fout,
  input  wire logic                take
);
  import crtr_pkg::*;

  localparam int DEPTH = 2;

  digit_t      mem [DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;
  logic signed [31:0] diff;
  digit_t      cls;

  assign full    = (count == 2'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = take && (count != 2'd0);

  always_comb begin
    diff         = $signed({1'b0, item.residue_p2}) - $signed({1'b0, item.residue_p1});
    cls.r1       = item.residue_p1;
    cls.diff_neg = diff[31];
    cls.diff_mag = diff[31] ? 31'(-diff) : diff[30:0];
    cls.last     = item.last_digit;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  assign fout.avail = (count != 2'd0);
  assign fout.digit = mem[rd_ptr];

endmodule

`default_nettype wire

// ===== sv/crtr_back.sv =====
// ----------------------------------------------------------------------------
// crtr_back
// garner step with a bit-serial remainder unit, fold, accumulate, limb output
// ----------------------------------------------------------------------------
`default_nettype none

module crtr_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire crtr_pkg::cfg_t       cfg,
  input  wire crtr_pkg::front_out_t fout,
  output logic                      take,
  output logic                      res_push,
  output crtr_pkg::result_t         res,
  input  wire logic                 res_full
);
  import crtr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_REM1  = 11'b00000000010,
    S_MUL1  = 11'b00000000100,
    S_REM2  = 11'b00000001000,
    S_MUL2  = 11'b00000010000,
    S_SUM   = 11'b00000100000,
    S_FOLD  = 11'b00001000000,
    S_SHIFT = 11'b00010000000,
    S_ADD   = 11'b00100000000,
    S_LIMB  = 11'b01000000000,
    S_FLUSH = 11'b10000000000
  } state_t;

  state_t                 state;
  logic [DIV_WIDTH-1:0]   sh;
  logic [CNT_WIDTH-1:0]   cnt;
  logic [30:0]            rem;
  logic [30:0]            r1;
  logic                   neg;
  logic                   last;
  logic [61:0]            pm;
  logic [63:0]            x;
  logic [63:0]            mag;
  logic                   xneg;
  logic [ACC_WIDTH-1:0]   addend;
  logic [ACC_WIDTH-1:0]   pos_acc;
  logic [ACC_WIDTH-1:0]   neg_acc;
  logic [OFS_WIDTH-1:0]   offset;
  logic                   flush_hi;

  logic [31:0]            rem_sh;
  logic [31:0]            p2_ext;
  logic [30:0]            rem_next;
  logic [63:0]            half64;
  logic [63:0]            x_fold;
  logic [OFS_WIDTH-1:0]   ofs_sum;

  always_comb begin
    rem_sh   = {rem, sh[DIV_WIDTH-1]};
    p2_ext   = {1'b0, cfg.prime_two};
    rem_next = (rem_sh >= p2_ext) ? 31'(rem_sh - p2_ext) : rem_sh[30:0];
    half64   = {3'b0, cfg.half_modulus_product};
    if ($signed(x) > $signed(half64)) begin
      x_fold = x - {2'b0, cfg.modulus_product};
    end else if ($signed(x) < -$signed(half64)) begin
      x_fold = x + {2'b0, cfg.modulus_product};
    end else begin
      x_fold = x;
    end
    ofs_sum = offset + {1'b0, cfg.digit_bits};
  end

  assign take = (state == S_IDLE) && fout.avail;

  always_comb begin
    res_push      = 1'b0;
    res.pos_limb  = pos_acc[LIMB_WIDTH-1:0];
    res.neg_limb  = neg_acc[LIMB_WIDTH-1:0];
    res.last_limb = 1'b0;
    if (state == S_LIMB) begin
      res_push = !res_full;
    end else if (state == S_FLUSH) begin
      res_push = !res_full;
      if (flush_hi) begin
        res.pos_limb  = pos_acc[ACC_WIDTH-1:LIMB_WIDTH];
        res.neg_limb  = neg_acc[ACC_WIDTH-1:LIMB_WIDTH];
        res.last_limb = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos_acc  <= '0;
      neg_acc  <= '0;
      offset   <= '0;
      flush_hi <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fout.avail) begin
            r1   <= fout.digit.r1;
            neg  <= fout.digit.diff_neg;
            last <= fout.digit.last;
            rem  <= '0;
            sh   <= {1'b0, fout.digit.diff_mag, 31'b0};
            cnt  <= CNT_WIDTH'(32);
            state <= (cfg.prime_two == '0) ? S_MUL2 : S_REM1;
          end
        end
        S_REM1, S_REM2: begin
          rem <= rem_next;
          sh  <= sh << 1;
          cnt <= cnt - CNT_WIDTH'(1);
          if (cnt == CNT_WIDTH'(1)) begin
            state <= (state == S_REM1) ? S_MUL1 : S_MUL2;
          end
        end
        S_MUL1: begin
          sh    <= {1'b0, 62'(rem) * 62'(cfg.inverse_p1_mod_p2)};
          rem   <= '0;
          cnt   <= CNT_WIDTH'(DIV_WIDTH);
          state <= S_REM2;
        end
        S_MUL2: begin
          pm    <= 62'(rem) * 62'(cfg.prime_one);
          state <= S_SUM;
        end
        S_SUM: begin
          x     <= {33'b0, r1} + (neg ? -{2'b0, pm} : {2'b0, pm});
          state <= S_FOLD;
        end
        S_FOLD: begin
          xneg  <= x_fold[63];
          mag   <= x_fold[63] ? -x_fold : x_fold;
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          addend <= {64'b0, mag} << offset[5:0];
          state  <= S_ADD;
        end
        S_ADD: begin
          if (xneg) begin
            neg_acc <= neg_acc + addend;
          end else begin
            pos_acc <= pos_acc + addend;
          end
          offset   <= ofs_sum;
          flush_hi <= 1'b0;
          if (ofs_sum[OFS_WIDTH-1]) begin
            state <= S_LIMB;
          end else if (last) begin
            state <= S_FLUSH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LIMB: begin
          if (!res_full) begin
            pos_acc <= {64'b0, pos_acc[ACC_WIDTH-1:LIMB_WIDTH]};
            neg_acc <= {64'b0, neg_acc[ACC_WIDTH-1:LIMB_WIDTH]};
            offset  <= {1'b0, offset[OFS_WIDTH-2:0]};
            state   <= last ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!res_full) begin
            if (flush_hi) begin
              pos_acc  <= '0;
              neg_acc  <= '0;
              offset   <= '0;
              flush_hi <= 1'b0;
              state    <= S_IDLE;
            end else begin
              flush_hi <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/crtr_res_queue.sv =====
// ----------------------------------------------------------------------------
// crtr_res_queue
// result queue between the back end and the output side
// ----------------------------------------------------------------------------
`default_nettype none

module crtr_res_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire crtr_pkg::result_t  wr_data,
  output logic                    qfull,
  output logic                    empty,
  input  wire logic               pop,
  output crtr_pkg::result_t       result
);
  import crtr_pkg::*;

  localparam int DEPTH = 4;

  result_t     mem [DEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        do_wr;
  logic        do_rd;

  assign qfull  = (count == 3'(DEPTH));
  assign empty  = (count == 3'd0);
  assign do_wr  = wr && !qfull;
  assign do_rd  = pop && !empty;
  assign result = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 2'd1;
      if (do_rd) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(do_wr) - 3'(do_rd);
    end
  end

endmodule

`default_nettype wire

// ===== sv/crt_two_prime_limb_recombine_top.sv =====
// ----------------------------------------------------------------------------
// crt_two_prime_limb_recombine_top
// two-prime crt digit rebuild with packing into 64-bit limb pairs
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// input    | push / full        | item (residue_p1, residue_p2, last_digit)
// result   | pop / empty        | result (pos_limb, neg_limb, last_limb)
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// in the back end a digit runs through take, two serial remainder passes of the
// shared divider (32 and 63 steps), two multiplies, sum, fold, shift and add,
// then one limb pair per cycle (0 to 3) while the result queue is not full.
// with prime_two zero the remainder passes and the first multiply are skipped.
// a two-entry input queue and a four-entry result queue decouple both sides;
// a full result queue holds the back end in its limb states.
// synchronous reset clears queues, accumulators, offset and flush flag and loads config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_two_prime_limb_recombine_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire crtr_pkg::item_t                   item,
  output logic                                   empty,
  input  wire logic                              pop,
  output crtr_pkg::result_t                      result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [crtr_pkg::IDX_WIDTH-1:0]    cfg_index,
  input  wire logic [crtr_pkg::CFG_WIDTH-1:0]    cfg_data
);
  import crtr_pkg::*;

  cfg_t        cfg;
  front_out_t  fout;
  logic        take;
  logic        res_push;
  result_t     res;
  logic        res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prime_one            <= 31'd2;
      cfg.prime_two            <= 31'd3;
      cfg.inverse_p1_mod_p2    <= 31'd2;
      cfg.digit_bits           <= 6'd32;
      cfg.modulus_product      <= 62'd6;
      cfg.half_modulus_product <= 61'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRIME_ONE: cfg.prime_one            <= cfg_data[30:0];
        REG_PRIME_TWO: cfg.prime_two            <= cfg_data[30:0];
        REG_INVERSE:   cfg.inverse_p1_mod_p2    <= cfg_data[30:0];
        REG_DIGIT:     cfg.digit_bits           <= cfg_data[5:0];
        REG_PROD:      cfg.modulus_product      <= cfg_data[61:0];
        REG_HALF:      cfg.half_modulus_product <= cfg_data[60:0];
        default: ;
      endcase
    end
  end

  crtr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .fout (fout),
    .take (take)
  );

  crtr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fout     (fout),
    .take     (take),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  crtr_res_queue u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res),
    .qfull   (res_full),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ===== sv/crtr_checker.sv =====
// ----------------------------------------------------------------------------
// crtr_checker
// port-level checks of the crt limb recombiner, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crtr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire crtr_pkg::result_t  result,
  input wire logic               cfg_ready
);
  import crtr_pkg::*;

  `AST_NEXT_ALWAYS(a_reset_clears, clk, rst, empty && !full)
  `AST_SAME(a_cfg_always_ready, clk, rst, 1'b1, cfg_ready)
  `AST_NEXT(a_result_stays, clk, rst, !empty && !pop, !empty)
  `AST_NEXT(a_result_holds, clk, rst, !empty && !pop, $stable(result))

endmodule

bind crt_two_prime_limb_recombine_top crtr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .result    (result),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
